@@ src/assert_macros.svh @@
// Assertion macros shared by the sorted key-value list modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/skvl_pkg.sv @@
// Package with the types and constants of the sorted key-value list.
package skvl_pkg;

	localparam int DATA_W       = 32;
	localparam int ACTION_W     = 2;
	localparam int STATUS_W     = 2;
	localparam int CAPACITY_DEF = 16;

	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} skvl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} skvl_cmd_t;

endpackage

@@ src/skvl_ctrl.sv @@
// Controller state machine that sequences each request through the table.
`include "assert_macros.svh"

module skvl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output skvl_pkg::skvl_cmd_t cmd
);
	import skvl_pkg::*;

	skvl_state_t state_q, state_d;
	logic        rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_EXEC: begin
				cmd.exec = !rsp_valid_q || rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	`ASSERT_NEXT(a_exec_gives_rsp, clk, arst_n, cmd.exec, rsp_valid_q, "result not presented")
	`ASSERT_ALWAYS(a_load_idle, clk, arst_n, !cmd.load || state_q == S_IDLE, "load outside idle")

endmodule

@@ src/skvl_datapath.sv @@
// Datapath with the sorted row of entry cells, the compare logic and the result register.
`include "assert_macros.svh"

module skvl_datapath #(
	parameter int CAPACITY = skvl_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skvl_pkg::skvl_cmd_t               cmd,
	input  logic [skvl_pkg::ACTION_W-1:0]     action,
	input  logic signed [skvl_pkg::DATA_W-1:0] key,
	input  logic signed [skvl_pkg::DATA_W-1:0] entry_value,
	output logic [skvl_pkg::STATUS_W-1:0]     status,
	output logic signed [skvl_pkg::DATA_W-1:0] found_value
);
	import skvl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [ACTION_W-1:0]      action_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] value_q;

	logic signed [DATA_W-1:0] keys_q [CAPACITY];
	logic signed [DATA_W-1:0] vals_q [CAPACITY];
	logic [CW-1:0]            count_q;

	logic [CAPACITY-1:0] valid;
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] hit;
	logic [DATA_W-1:0]   hit_val;
	logic                hit_any;
	logic                full;
	logic                do_ins;
	logic                do_rem;
	logic [STATUS_W-1:0] status_d;
	logic [DATA_W-1:0]   result_d;

	logic [STATUS_W-1:0]      status_q;
	logic signed [DATA_W-1:0] found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			key_q    <= key;
			value_q  <= entry_value;
		end
	end

	always_comb begin
		hit_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			valid[i] = count_q > CW'(i);
			lt[i]    = valid[i] && (keys_q[i] < key_q);
			hit[i]   = valid[i] && (keys_q[i] == key_q);
			hit_val  = hit_val | (hit[i] ? vals_q[i] : '0);
		end
	end

	assign hit_any = |hit;
	assign full    = count_q == CW'(CAPACITY);

	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		status_d = ST_ABSENT;
		result_d = '0;
		unique case (action_q)
			ACT_INSERT: begin
				if (hit_any) status_d = ST_DUP;
				else if (full) status_d = ST_FULL;
				else begin
					status_d = ST_OK;
					do_ins   = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (hit_any) begin
					status_d = ST_OK;
					result_d = hit_val;
					do_rem   = 1'b1;
				end
			end
			default: begin
				if (hit_any) begin
					status_d = ST_OK;
					result_d = hit_val;
				end
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] ins_key, ins_val;
		logic signed [DATA_W-1:0] rem_key, rem_val;

		if (i == 0) begin : g_first
			assign ins_key = key_q;
			assign ins_val = value_q;
		end else begin : g_rest
			assign ins_key = lt[i-1] ? key_q : keys_q[i-1];
			assign ins_val = lt[i-1] ? value_q : vals_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rem_key = keys_q[i];
			assign rem_val = vals_q[i];
		end else begin : g_inner
			assign rem_key = keys_q[i+1];
			assign rem_val = vals_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec && !lt[i]) begin
				if (do_ins) begin
					keys_q[i] <= ins_key;
					vals_q[i] <= ins_val;
				end else if (do_rem) begin
					keys_q[i] <= rem_key;
					vals_q[i] <= rem_val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_ins) count_q <= count_q + CW'(1);
			else if (do_rem) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			found_q  <= result_d;
		end
	end

	assign status      = status_q;
	assign found_value = found_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY), "count over capacity")
	`ASSERT_ALWAYS(a_hit_unique, clk, arst_n, $onehot0(hit), "duplicate keys stored")
	`ASSERT_NEXT(a_ins_count, clk, arst_n, cmd.exec && do_ins, count_q == $past(count_q) + CW'(1), "insert count")

endmodule

@@ src/sorted_key_value_list.sv @@
// Top level of the sorted key-value list: controller plus entry datapath.
// Each request is handled in two steps: idle registers it, then exec compares all entries and updates.
// A new request is taken only in idle, once the one before has executed; exec waits for an untaken result.
// The result is registered when the request executes and stays until taken.
// The single compare-and-shift step over the whole entry row does each update.
// Reset clears the entry count and handshake state; stored entries are left unchanged.
module sorted_key_value_list #(
	parameter int CAPACITY = skvl_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [skvl_pkg::ACTION_W-1:0]      action,
	input  logic signed [skvl_pkg::DATA_W-1:0] key,
	input  logic signed [skvl_pkg::DATA_W-1:0] entry_value,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [skvl_pkg::STATUS_W-1:0]      status,
	output logic signed [skvl_pkg::DATA_W-1:0] found_value
);
	import skvl_pkg::*;

	skvl_cmd_t cmd;

	skvl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	skvl_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.key         (key),
		.entry_value (entry_value),
		.status      (status),
		.found_value (found_value)
	);

endmodule

@@ sim/skvl_checker.sv @@
// Checker for the sorted key-value list: predicts each result and compares it.
`timescale 1ns / 100ps

module skvl_checker #(
	parameter int CAPACITY = skvl_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_ready,
	input  logic [skvl_pkg::ACTION_W-1:0]       action,
	input  logic signed [skvl_pkg::DATA_W-1:0]  key,
	input  logic signed [skvl_pkg::DATA_W-1:0]  entry_value,
	input  logic                                rsp_valid,
	input  logic                                rsp_ready,
	input  logic [skvl_pkg::STATUS_W-1:0]       status,
	input  logic signed [skvl_pkg::DATA_W-1:0]  found_value,
	output int                                  fail_count,
	output int                                  pending
);
	import skvl_pkg::*;

	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] found_value;
	} result_t;

	logic signed [DATA_W-1:0] held_keys   [CAPACITY];
	logic signed [DATA_W-1:0] held_values [CAPACITY];
	int                       held_count;
	result_t                  expected_results [$];

	function automatic result_t apply_request(input logic [ACTION_W-1:0] act,
			input logic signed [DATA_W-1:0] k, input logic signed [DATA_W-1:0] v);
		result_t res;
		int      pos;
		logic    hit;
		res.status = ST_ABSENT;
		res.found_value = '0;
		pos = 0;
		while (pos < held_count && held_keys[pos] < k)
			pos++;
		hit = (pos < held_count) && (held_keys[pos] == k);
		case (act)
			ACT_INSERT: begin
				if (hit) begin
					res.status = ST_DUP;
				end else if (held_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = held_count; i > pos; i--) begin
						held_keys[i] = held_keys[i-1];
						held_values[i] = held_values[i-1];
					end
					held_keys[pos] = k;
					held_values[pos] = v;
					held_count++;
					res.status = ST_OK;
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					res.found_value = held_values[pos];
					for (int i = pos; i < held_count - 1; i++) begin
						held_keys[i] = held_keys[i+1];
						held_values[i] = held_values[i+1];
					end
					held_count--;
					res.status = ST_OK;
				end
			end
			default: begin
				// The unused action code is treated as a lookup.
				if (hit) begin
					res.found_value = held_values[pos];
					res.status = ST_OK;
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t oldest;
		if (!arst_n) begin
			held_count = 0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got status %0d value %0d",
						$time, status, found_value);
				end else begin
					oldest = expected_results.pop_front();
					if (status !== oldest.status) begin
						fail_count++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, oldest.status, status);
					end
					if (found_value !== oldest.found_value) begin
						fail_count++;
						$display("%0t: found_value mismatch, expected %0d, got %0d",
							$time, oldest.found_value, found_value);
					end
				end
			end
			if (req_valid && req_ready)
				expected_results.push_back(apply_request(action, key, entry_value));
			pending = expected_results.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top for the sorted key-value list: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module tb;
	import skvl_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_REQUESTS = 1300;
	localparam int HOLD_OFF_CYCLES = 80;

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_ready;
	logic [ACTION_W-1:0]      action;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] entry_value;
	logic                     rsp_valid;
	logic                     rsp_ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] found_value;
	int                       fail_count;
	int                       pending;

	logic                     send_gaps_on;
	logic                     rsp_gaps_on;
	logic                     hold_off_request;
	logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

	sorted_key_value_list dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.key        (key),
		.entry_value(entry_value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.found_value(found_value)
	);

	skvl_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.key        (key),
		.entry_value(entry_value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.found_value(found_value),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin : receiver
		int   stall_left;
		logic hold_off_done;
		rsp_ready = 1'b0;
		stall_left = 0;
		hold_off_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_request && !hold_off_done) begin
				hold_off_done = 1'b1;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= !(rsp_gaps_on && $urandom_range(99) < 27);
			end
		end
	end

	task automatic send_request(input logic [ACTION_W-1:0] act,
			input logic signed [DATA_W-1:0] k, input logic signed [DATA_W-1:0] v);
		@(negedge clk);
		while (send_gaps_on && $urandom_range(99) < 27) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		key <= k;
		entry_value <= v;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int                       r;
		logic [ACTION_W-1:0]      act;
		logic signed [DATA_W-1:0] k;
		req_valid = 1'b0;
		action = ACT_LOOKUP;
		key = '0;
		entry_value = '0;
		arst_n = 1'b0;
		send_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		hold_off_request = 1'b0;
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = '0;
		key_pool[3] = -1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(ACT_LOOKUP, 0, $urandom);
		send_request(ACT_REMOVE, 0, $urandom);
		send_request(ACT_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
		send_request(ACT_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
		send_request(ACT_INSERT, 0, -1);
		send_request(ACT_INSERT, 0, 5);
		send_request(ACT_LOOKUP, 32'sh8000_0000, $urandom);
		send_request(ACT_UNUSED, 32'sh7fff_ffff, $urandom);
		send_request(ACT_REMOVE, 0, $urandom);
		for (int n = 0; n < 14; n++)
			send_request(ACT_INSERT, (n % 2) ? 100 * (n + 1) : -100 * (n + 1), $urandom);
		send_request(ACT_INSERT, 7, $urandom);
		send_request(ACT_INSERT, 32'sh7fff_ffff, $urandom);
		wait_drained();

		// The result side holds off while requests keep coming, so the block backs up.
		send_gaps_on = 1'b0;
		hold_off_request = 1'b1;
		for (int n = 0; n < 12; n++)
			send_request(ACT_LOOKUP, key_pool[$urandom_range(POOL_SIZE - 1)], $urandom);
		send_gaps_on = 1'b1;

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 500) begin
				send_gaps_on = 1'b0;
				rsp_gaps_on = 1'b0;
			end else if (n == 650) begin
				wait_drained();
				send_gaps_on = 1'b1;
				rsp_gaps_on = 1'b1;
			end
			r = $urandom_range(99);
			if ((n / 100) % 2 == 0)
				act = (r < 55) ? ACT_INSERT : (r < 75) ? ACT_REMOVE :
					(r < 95) ? ACT_LOOKUP : ACT_UNUSED;
			else
				act = (r < 20) ? ACT_INSERT : (r < 60) ? ACT_REMOVE :
					(r < 95) ? ACT_LOOKUP : ACT_UNUSED;
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = $urandom;
			send_request(act, k, $urandom);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sorted_key_value_list.f @@
+incdir+src
src/skvl_pkg.sv
src/skvl_ctrl.sv
src/skvl_datapath.sv
src/sorted_key_value_list.sv
sim/skvl_checker.sv
sim/tb.sv
